@@ rtl/core/oled_page_framebuffer_text_engine_core_defines.svh @@
// Assertion macros for the OLED page framebuffer text engine core.
// No dependencies; included by files that carry concurrent assertions.
// Building with NO_ASSERTIONS defined turns every assertion into nothing.
`ifndef OLED_PAGE_FRAMEBUFFER_TEXT_ENGINE_CORE_DEFINES_SVH
`define OLED_PAGE_FRAMEBUFFER_TEXT_ENGINE_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Antecedent implies consequent in the same cycle
`define OPFTE_ASSERT_SAME(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle
`define OPFTE_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`else

`define OPFTE_ASSERT_SAME(label, ck, rn, ante, cons, msg)
`define OPFTE_ASSERT_NEXT(label, ck, rn, ante, cons, msg)

`endif

`endif

@@ rtl/core/opfte_pkg.sv @@
// Shared types, microcode table and font table for the framebuffer text engine.
// No dependencies; used by the interfaces, the sequencer and the top level.
`default_nettype none

package opfte_pkg;

    // Input item kinds
    typedef enum logic [1:0] {
        KIND_CLEAR = 2'd0,
        KIND_PIXEL = 2'd1,
        KIND_CHAR  = 2'd2,
        KIND_FLUSH = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] x_pos;
        logic [7:0] y_pos;
        logic       pixel_on;
        logic [7:0] fill_byte;
        logic [7:0] char_code;
        logic [2:0] page_index;
        logic [2:0] chunk_index;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       packet_first;
        logic       packet_last;
        logic       run_last;
    } out_item_t;

    // Controller stream bytes
    localparam logic [7:0] CTRL_CMD      = 8'h00;
    localparam logic [7:0] CTRL_DATA     = 8'h40;
    localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
    localparam logic [7:0] CMD_COL_LOW   = 8'h00;
    localparam logic [7:0] CMD_COL_HIGH  = 8'h10;

    // Glyph cell geometry and header length
    localparam logic [2:0] COL_LAST = 3'd4;
    localparam logic [2:0] ROW_LAST = 3'd6;
    localparam logic [2:0] HDR_LAST = 3'd5;
    localparam int         GLYPH_MARGIN = 6;

    // Datapath actions of one step
    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_WR_FILL,
        ACT_RD_PIX,
        ACT_WR_PIX,
        ACT_RD_FLUSH
    } act_t;

    // Branch conditions
    typedef enum logic [3:0] {
        C_NEVER,
        C_DISPATCH,
        C_SWEEP_MORE,
        C_CHAR_FAR,
        C_CHAR_MORE,
        C_CHUNK_NZ,
        C_HDR_MORE,
        C_IDX_MORE
    } cond_t;

    // Output beat source
    typedef enum logic [1:0] {
        SRC_NONE,
        SRC_HDR,
        SRC_CMD,
        SRC_DATA
    } src_t;

    typedef logic [3:0] upc_t;

    localparam upc_t UPC_IDLE    = 4'd0;
    localparam upc_t UPC_SWEEP   = 4'd1;
    localparam upc_t UPC_PIX_RD  = 4'd2;
    localparam upc_t UPC_PIX_WR  = 4'd3;
    localparam upc_t UPC_CHR_CHK = 4'd4;
    localparam upc_t UPC_CHR_RD  = 4'd5;
    localparam upc_t UPC_CHR_WR  = 4'd6;
    localparam upc_t UPC_FL_CHK  = 4'd7;
    localparam upc_t UPC_FL_HDR  = 4'd8;
    localparam upc_t UPC_FL_CMD  = 4'd9;
    localparam upc_t UPC_FL_RD   = 4'd10;
    localparam upc_t UPC_FL_DATA = 4'd11;

    typedef struct packed {
        act_t  act;
        cond_t cond;
        src_t  src;
        logic  done;
        upc_t  target;
    } ctrl_word_t;

    // Status flags from the datapath to the sequencer
    typedef struct packed {
        logic  accept;
        kind_t kind;
        logic  stall;
        logic  sweep_more;
        logic  char_far;
        logic  char_more;
        logic  chunk_nz;
        logic  hdr_more;
        logic  idx_more;
    } seq_status_t;

    // Microcode program: if cond holds jump to target (dispatch jumps to the entry
    // step of the item's kind), else done returns to idle, else fall through to the next step.
    function automatic ctrl_word_t ucode_word(input upc_t upc);
        ctrl_word_t w;
        case (upc)
            UPC_IDLE:    w = '{ACT_NONE,     C_DISPATCH,   SRC_NONE, 1'b1, UPC_IDLE};
            UPC_SWEEP:   w = '{ACT_WR_FILL,  C_SWEEP_MORE, SRC_NONE, 1'b1, UPC_SWEEP};
            UPC_PIX_RD:  w = '{ACT_RD_PIX,   C_NEVER,      SRC_NONE, 1'b0, UPC_IDLE};
            UPC_PIX_WR:  w = '{ACT_WR_PIX,   C_NEVER,      SRC_NONE, 1'b1, UPC_IDLE};
            UPC_CHR_CHK: w = '{ACT_NONE,     C_CHAR_FAR,   SRC_NONE, 1'b0, UPC_IDLE};
            UPC_CHR_RD:  w = '{ACT_RD_PIX,   C_NEVER,      SRC_NONE, 1'b0, UPC_IDLE};
            UPC_CHR_WR:  w = '{ACT_WR_PIX,   C_CHAR_MORE,  SRC_NONE, 1'b1, UPC_CHR_RD};
            UPC_FL_CHK:  w = '{ACT_NONE,     C_CHUNK_NZ,   SRC_NONE, 1'b0, UPC_FL_CMD};
            UPC_FL_HDR:  w = '{ACT_NONE,     C_HDR_MORE,   SRC_HDR,  1'b0, UPC_FL_HDR};
            UPC_FL_CMD:  w = '{ACT_NONE,     C_NEVER,      SRC_CMD,  1'b0, UPC_IDLE};
            UPC_FL_RD:   w = '{ACT_RD_FLUSH, C_NEVER,      SRC_NONE, 1'b0, UPC_IDLE};
            UPC_FL_DATA: w = '{ACT_NONE,     C_IDX_MORE,   SRC_DATA, 1'b1, UPC_FL_RD};
            default:     w = '{ACT_NONE,     C_NEVER,      SRC_NONE, 1'b1, UPC_IDLE};
        endcase
        return w;
    endfunction

    // Pack five glyph columns, column 0 in the low byte
    function automatic logic [39:0] glyph5(input logic [7:0] c0, input logic [7:0] c1,
                                           input logic [7:0] c2, input logic [7:0] c3,
                                           input logic [7:0] c4);
        return {c4, c3, c2, c1, c0};
    endfunction

    // 5x7 font; lowercase folds to uppercase, codes without a glyph are blank
    function automatic logic [39:0] glyph_bits(input logic [7:0] code);
        logic [7:0]  folded;
        logic [39:0] g;
        folded = code;
        if (code inside {[8'h61:8'h7A]}) begin
            folded = code - 8'h20;
        end
        case (folded)
            8'h25: g = glyph5(8'h63, 8'h13, 8'h08, 8'h64, 8'h63);
            8'h2D: g = glyph5(8'h08, 8'h08, 8'h08, 8'h08, 8'h08);
            8'h2E: g = glyph5(8'h00, 8'h60, 8'h60, 8'h00, 8'h00);
            8'h2F: g = glyph5(8'h20, 8'h10, 8'h08, 8'h04, 8'h02);
            8'h30: g = glyph5(8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E);
            8'h31: g = glyph5(8'h00, 8'h42, 8'h7F, 8'h40, 8'h00);
            8'h32: g = glyph5(8'h62, 8'h51, 8'h49, 8'h49, 8'h46);
            8'h33: g = glyph5(8'h22, 8'h49, 8'h49, 8'h49, 8'h36);
            8'h34: g = glyph5(8'h18, 8'h14, 8'h12, 8'h7F, 8'h10);
            8'h35: g = glyph5(8'h2F, 8'h49, 8'h49, 8'h49, 8'h31);
            8'h36: g = glyph5(8'h3E, 8'h49, 8'h49, 8'h49, 8'h32);
            8'h37: g = glyph5(8'h01, 8'h71, 8'h09, 8'h05, 8'h03);
            8'h38: g = glyph5(8'h36, 8'h49, 8'h49, 8'h49, 8'h36);
            8'h39: g = glyph5(8'h26, 8'h49, 8'h49, 8'h49, 8'h3E);
            8'h3A: g = glyph5(8'h00, 8'h36, 8'h36, 8'h00, 8'h00);
            8'h3C: g = glyph5(8'h08, 8'h14, 8'h22, 8'h41, 8'h00);
            8'h3E: g = glyph5(8'h41, 8'h22, 8'h14, 8'h08, 8'h00);
            8'h41: g = glyph5(8'h7E, 8'h09, 8'h09, 8'h09, 8'h7E);
            8'h42: g = glyph5(8'h7F, 8'h49, 8'h49, 8'h49, 8'h36);
            8'h43: g = glyph5(8'h3E, 8'h41, 8'h41, 8'h41, 8'h22);
            8'h44: g = glyph5(8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C);
            8'h45: g = glyph5(8'h7F, 8'h49, 8'h49, 8'h49, 8'h41);
            8'h46: g = glyph5(8'h7F, 8'h09, 8'h09, 8'h09, 8'h01);
            8'h47: g = glyph5(8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A);
            8'h48: g = glyph5(8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F);
            8'h49: g = glyph5(8'h00, 8'h41, 8'h7F, 8'h41, 8'h00);
            8'h4A: g = glyph5(8'h20, 8'h40, 8'h41, 8'h3F, 8'h01);
            8'h4B: g = glyph5(8'h7F, 8'h08, 8'h14, 8'h22, 8'h41);
            8'h4C: g = glyph5(8'h7F, 8'h40, 8'h40, 8'h40, 8'h40);
            8'h4D: g = glyph5(8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F);
            8'h4E: g = glyph5(8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F);
            8'h4F: g = glyph5(8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E);
            8'h50: g = glyph5(8'h7F, 8'h09, 8'h09, 8'h09, 8'h06);
            8'h51: g = glyph5(8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E);
            8'h52: g = glyph5(8'h7F, 8'h09, 8'h19, 8'h29, 8'h46);
            8'h53: g = glyph5(8'h46, 8'h49, 8'h49, 8'h49, 8'h31);
            8'h54: g = glyph5(8'h01, 8'h01, 8'h7F, 8'h01, 8'h01);
            8'h55: g = glyph5(8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F);
            8'h56: g = glyph5(8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F);
            8'h57: g = glyph5(8'h7F, 8'h20, 8'h18, 8'h20, 8'h7F);
            8'h58: g = glyph5(8'h63, 8'h14, 8'h08, 8'h14, 8'h63);
            8'h59: g = glyph5(8'h03, 8'h04, 8'h78, 8'h04, 8'h03);
            8'h5A: g = glyph5(8'h61, 8'h51, 8'h49, 8'h45, 8'h43);
            default: g = '0;
        endcase
        return g;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/opfte_if.sv @@
// Valid/ready stream interfaces for the item and result channels.
// Depends on opfte_pkg for the payload types.
`default_nettype none

interface opfte_in_if;
    logic                valid;
    logic                ready;
    opfte_pkg::in_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface opfte_out_if;
    logic                 valid;
    logic                 ready;
    opfte_pkg::out_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ rtl/core/opfte_useq.sv @@
// Microcode sequencer: step counter, control word lookup and branch logic.
// Depends on opfte_pkg for the control word, status struct and program.
`default_nettype none

module opfte_useq (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire opfte_pkg::seq_status_t status,
    output opfte_pkg::ctrl_word_t       word
);
    import opfte_pkg::*;

    upc_t upc_reg;
    upc_t upc_next;
    logic taken;

    assign word = ucode_word(upc_reg);

    // Entry step for each item kind
    function automatic upc_t entry_of(input kind_t k);
        upc_t e;
        case (k)
            KIND_CLEAR: e = UPC_SWEEP;
            KIND_PIXEL: e = UPC_PIX_RD;
            KIND_CHAR:  e = UPC_CHR_CHK;
            KIND_FLUSH: e = UPC_FL_CHK;
            default:    e = UPC_IDLE;
        endcase
        return e;
    endfunction

    // Branch condition select
    always_comb
    begin
        case (word.cond)
            C_NEVER:      taken = 1'b0;
            C_DISPATCH:   taken = status.accept;
            C_SWEEP_MORE: taken = status.sweep_more;
            C_CHAR_FAR:   taken = status.char_far;
            C_CHAR_MORE:  taken = status.char_more;
            C_CHUNK_NZ:   taken = status.chunk_nz;
            C_HDR_MORE:   taken = status.hdr_more;
            C_IDX_MORE:   taken = status.idx_more;
            default:      taken = 1'b0;
        endcase
    end

    // Next step
    always_comb
    begin
        if (status.stall) begin
            upc_next = upc_reg;
        end else if (taken) begin
            upc_next = (word.cond == C_DISPATCH) ? entry_of(status.kind) : word.target;
        end else if (word.done) begin
            upc_next = UPC_IDLE;
        end else begin
            upc_next = upc_t'(upc_reg + 1'b1);
        end
    end

    // Reset starts the clearing sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            upc_reg <= UPC_SWEEP;
        end else begin
            upc_reg <= upc_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/oled_page_framebuffer_text_engine_core.sv @@
// Each step makes at most one frame store access: clear writes the fill byte to every address,
// set pixel and each glyph pixel are a read step then a read-modify-write step, and a flush
// sends the command header (chunk 0 only) and the data control byte, then reads and sends
// each chunk byte in turn. An output step waits while the previous beat is not yet taken.
// Reset: asynchronous, active low; afterwards a clearing sweep zeroes the store,
// and no item is accepted until it finishes.
`default_nettype none
`include "oled_page_framebuffer_text_engine_core_defines.svh"

module oled_page_framebuffer_text_engine_core #(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 64,
    parameter int CHUNK_BYTES   = 16
) (
    input wire logic   clk,
    input wire logic   rst_n,
    opfte_in_if.sink   item,
    opfte_out_if.source result
);
    import opfte_pkg::*;

    localparam int PAGE_COUNT = (SCREEN_HEIGHT + 7) / 8;
    localparam int DEPTH      = SCREEN_WIDTH * PAGE_COUNT;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int IDX_W      = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1;

    ctrl_word_t  word;
    seq_status_t status;

    logic accept;
    logic stall;
    logic go;
    logic load_out;

    // Control registers
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [7:0]        fill_reg, fill_next;
    logic [2:0]        col_reg, col_next;
    logic [2:0]        row_reg, row_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [2:0]        hdr_reg, hdr_next;
    logic              out_valid_reg, out_valid_next;

    // Item payload registers
    logic [7:0]  x_reg;
    logic [7:0]  y_reg;
    logic        on_reg;
    logic        char_mode_reg;
    logic [39:0] glyph_reg;
    logic [2:0]  page_reg;
    logic [2:0]  chunk_reg;
    out_item_t   out_data_reg, out_data_next;

    // Frame store
    logic [7:0]        mem [DEPTH];
    logic [7:0]        rdata_reg;
    logic              mem_we;
    logic              mem_re;
    logic              fill_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [ADDR_W-1:0] mem_raddr;
    logic [7:0]        mem_wdata;

    // Pixel and flush addressing
    logic [7:0]        px;
    logic [7:0]        py;
    logic              on_screen;
    logic              pix_bit;
    logic [7:0]        pix_mask;
    logic [7:0]        pix_wdata;
    logic [ADDR_W-1:0] pix_addr;
    logic [8:0]        flush_col;
    logic              flush_in_range;
    logic [ADDR_W-1:0] flush_addr;
    logic              idx_last;

    opfte_useq u_useq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .word   (word)
    );

    // Handshake and stall
    assign item.ready   = (word.cond == C_DISPATCH);
    assign accept       = item.valid && item.ready;
    assign stall        = (word.src != SRC_NONE) && out_valid_reg && !result.ready;
    assign go           = !stall;
    assign load_out     = go && (word.src != SRC_NONE);
    assign result.valid = out_valid_reg;
    assign result.payload = out_data_reg;

    // Pixel position for set pixel and glyph cells, coordinates wrap mod 256
    assign px        = x_reg + {5'b0, col_reg};
    assign py        = y_reg + {5'b0, row_reg};
    assign on_screen = ({1'b0, px} < 9'(SCREEN_WIDTH)) && ({1'b0, py} < 9'(SCREEN_HEIGHT));
    assign pix_addr  = ADDR_W'(px) + ADDR_W'(py[7:3]) * ADDR_W'(SCREEN_WIDTH);
    assign pix_bit   = char_mode_reg ? glyph_reg[{col_reg, row_reg}] : on_reg;
    assign pix_mask  = 8'b1 << py[2:0];
    assign pix_wdata = pix_bit ? (rdata_reg | pix_mask) : (rdata_reg & ~pix_mask);

    // Flush column and range check
    assign flush_col      = 9'(chunk_reg) * 9'(CHUNK_BYTES) + 9'(idx_reg);
    assign flush_in_range = (5'(page_reg) < 5'(PAGE_COUNT)) && (flush_col < 9'(SCREEN_WIDTH));
    assign flush_addr     = ADDR_W'(page_reg) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(flush_col);
    assign idx_last       = (idx_reg == IDX_W'(CHUNK_BYTES - 1));

    // Store port control
    assign fill_we   = go && (word.act == ACT_WR_FILL);
    assign mem_we    = fill_we || (go && (word.act == ACT_WR_PIX) && on_screen);
    assign mem_waddr = fill_we ? addr_reg : pix_addr;
    assign mem_wdata = fill_we ? fill_reg : pix_wdata;
    assign mem_re    = go && ((word.act == ACT_RD_PIX) || (word.act == ACT_RD_FLUSH));
    assign mem_raddr = (word.act == ACT_RD_PIX) ? pix_addr : flush_addr;

    // Sequencer status
    always_comb
    begin
        status.accept     = accept;
        status.kind       = item.payload.kind;
        status.stall      = stall;
        status.sweep_more = (addr_reg != ADDR_W'(DEPTH - 1));
        status.char_far   = ({1'b0, x_reg} > 9'(SCREEN_WIDTH - GLYPH_MARGIN));
        status.char_more  = !((col_reg == COL_LAST) && (row_reg == ROW_LAST));
        status.chunk_nz   = (chunk_reg != 3'd0);
        status.hdr_more   = (hdr_reg != HDR_LAST);
        status.idx_more   = !idx_last;
    end

    // Counter updates
    always_comb
    begin
        addr_next = addr_reg;
        fill_next = fill_reg;
        col_next  = col_reg;
        row_next  = row_reg;
        idx_next  = idx_reg;
        hdr_next  = hdr_reg;
        if (accept) begin
            addr_next = '0;
            fill_next = item.payload.fill_byte;
            col_next  = '0;
            row_next  = '0;
            idx_next  = '0;
            hdr_next  = '0;
        end
        if (go) begin
            case (word.act)
                ACT_WR_FILL: addr_next = addr_reg + 1'b1;
                ACT_WR_PIX:
                begin
                    if (row_reg == ROW_LAST) begin
                        row_next = '0;
                        col_next = col_reg + 1'b1;
                    end else begin
                        row_next = row_reg + 1'b1;
                    end
                end
                default: ;
            endcase
            case (word.src)
                SRC_HDR:  hdr_next = hdr_reg + 1'b1;
                SRC_DATA: idx_next = idx_reg + 1'b1;
                default:  ;
            endcase
        end
    end

    // Output beat formation
    always_comb
    begin
        out_data_next = out_data_reg;
        case (word.src)
            SRC_HDR:
            begin
                case (hdr_reg)
                    3'd1:    out_data_next.out_byte = CMD_PAGE_BASE + {5'b0, page_reg};
                    3'd3:    out_data_next.out_byte = CMD_COL_LOW;
                    3'd5:    out_data_next.out_byte = CMD_COL_HIGH;
                    default: out_data_next.out_byte = CTRL_CMD;
                endcase
                out_data_next.packet_first = !hdr_reg[0];
                out_data_next.packet_last  = hdr_reg[0];
                out_data_next.run_last     = 1'b0;
            end
            SRC_CMD:
            begin
                out_data_next.out_byte     = CTRL_DATA;
                out_data_next.packet_first = 1'b1;
                out_data_next.packet_last  = 1'b0;
                out_data_next.run_last     = 1'b0;
            end
            SRC_DATA:
            begin
                out_data_next.out_byte     = flush_in_range ? rdata_reg : 8'h00;
                out_data_next.packet_first = 1'b0;
                out_data_next.packet_last  = idx_last;
                out_data_next.run_last     = idx_last;
            end
            default: ;
        endcase
    end

    assign out_valid_next = load_out ? 1'b1 : (result.ready ? 1'b0 : out_valid_reg);

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            addr_reg      <= '0;
            fill_reg      <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            idx_reg       <= '0;
            hdr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            addr_reg      <= addr_next;
            fill_reg      <= fill_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            idx_reg       <= idx_next;
            hdr_reg       <= hdr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Item and result payload
    always_ff @(posedge clk)
    begin
        if (accept) begin
            x_reg         <= item.payload.x_pos;
            y_reg         <= (item.payload.kind == KIND_CHAR || item.payload.kind == KIND_PIXEL)
                             ? item.payload.y_pos : y_reg;
            on_reg        <= item.payload.pixel_on;
            char_mode_reg <= (item.payload.kind == KIND_CHAR);
            glyph_reg     <= glyph_bits(item.payload.char_code);
            page_reg      <= item.payload.page_index;
            chunk_reg     <= item.payload.chunk_index;
        end
        if (load_out) begin
            out_data_reg <= out_data_next;
        end
    end

    // Frame store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    `OPFTE_ASSERT_NEXT(a_accept_starts, clk, rst_n, accept, !item.ready, "accepted beat left sequencer idle")
    `OPFTE_ASSERT_NEXT(a_run_end_idle, clk, rst_n, load_out && out_data_next.run_last, item.ready, "sequencer not idle after final beat")
    `OPFTE_ASSERT_SAME(a_idle_no_write, clk, rst_n, item.ready, !mem_we, "store written while idle")
    `OPFTE_ASSERT_NEXT(a_sweep_busy, clk, rst_n, fill_we && status.sweep_more, !item.ready, "item taken during fill sweep")

endmodule

`default_nettype wire

@@ bench/tb_oled_page_framebuffer_text_engine_core.sv @@
// Self-checking bench for the page-mode framebuffer text engine: it keeps a shadow
// framebuffer, predicts the controller byte stream of every flush and checks it beat by beat.
// Depends on opfte_pkg, opfte_if and the oled_page_framebuffer_text_engine_core RTL.
`timescale 1ns / 100ps

module tb_oled_page_framebuffer_text_engine_core;
    import opfte_pkg::*;

    localparam int SCR_W     = 128;
    localparam int SCR_H     = 64;
    localparam int CHUNK_LEN = 16;
    localparam int PAGES     = (SCR_H + 7) / 8;
    localparam int FB_BYTES  = SCR_W * PAGES;

    logic clk;
    logic rst_n;

    opfte_in_if  item_ch ();
    opfte_out_if result_ch ();

    oled_page_framebuffer_text_engine_core #(
        .SCREEN_WIDTH  (SCR_W),
        .SCREEN_HEIGHT (SCR_H),
        .CHUNK_BYTES   (CHUNK_LEN)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    // Shadow framebuffer and the bus bytes still owed by the block
    logic [7:0] shadow_fb [FB_BYTES];
    out_item_t  bus_bytes_due [$];

    bit idle_enabled;
    int items_accepted;
    int clears_seen, pixels_seen, chars_seen, flushes_seen;
    int beats_checked;
    int mismatch_count;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit: far above the slowest legal run
    initial
    begin
        #5_000_000;
        $display("Timeout: %0d beats still due", bus_bytes_due.size());
        $display("Test completed with failures");
        $finish;
    end

    // 5x7 font, column 0 first, bit 0 the top row
    function automatic logic [0:4][7:0] font_columns(input logic [7:0] ch);
        logic [0:4][7:0] g;
        case (ch)
            8'h25: g = {8'h63, 8'h13, 8'h08, 8'h64, 8'h63};
            8'h2D: g = {8'h08, 8'h08, 8'h08, 8'h08, 8'h08};
            8'h2E: g = {8'h00, 8'h60, 8'h60, 8'h00, 8'h00};
            8'h2F: g = {8'h20, 8'h10, 8'h08, 8'h04, 8'h02};
            8'h30: g = {8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E};
            8'h31: g = {8'h00, 8'h42, 8'h7F, 8'h40, 8'h00};
            8'h32: g = {8'h62, 8'h51, 8'h49, 8'h49, 8'h46};
            8'h33: g = {8'h22, 8'h49, 8'h49, 8'h49, 8'h36};
            8'h34: g = {8'h18, 8'h14, 8'h12, 8'h7F, 8'h10};
            8'h35: g = {8'h2F, 8'h49, 8'h49, 8'h49, 8'h31};
            8'h36: g = {8'h3E, 8'h49, 8'h49, 8'h49, 8'h32};
            8'h37: g = {8'h01, 8'h71, 8'h09, 8'h05, 8'h03};
            8'h38: g = {8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
            8'h39: g = {8'h26, 8'h49, 8'h49, 8'h49, 8'h3E};
            8'h3A: g = {8'h00, 8'h36, 8'h36, 8'h00, 8'h00};
            8'h3C: g = {8'h08, 8'h14, 8'h22, 8'h41, 8'h00};
            8'h3E: g = {8'h41, 8'h22, 8'h14, 8'h08, 8'h00};
            8'h41: g = {8'h7E, 8'h09, 8'h09, 8'h09, 8'h7E};
            8'h42: g = {8'h7F, 8'h49, 8'h49, 8'h49, 8'h36};
            8'h43: g = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h22};
            8'h44: g = {8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C};
            8'h45: g = {8'h7F, 8'h49, 8'h49, 8'h49, 8'h41};
            8'h46: g = {8'h7F, 8'h09, 8'h09, 8'h09, 8'h01};
            8'h47: g = {8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A};
            8'h48: g = {8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F};
            8'h49: g = {8'h00, 8'h41, 8'h7F, 8'h41, 8'h00};
            8'h4A: g = {8'h20, 8'h40, 8'h41, 8'h3F, 8'h01};
            8'h4B: g = {8'h7F, 8'h08, 8'h14, 8'h22, 8'h41};
            8'h4C: g = {8'h7F, 8'h40, 8'h40, 8'h40, 8'h40};
            8'h4D: g = {8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F};
            8'h4E: g = {8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F};
            8'h4F: g = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E};
            8'h50: g = {8'h7F, 8'h09, 8'h09, 8'h09, 8'h06};
            8'h51: g = {8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E};
            8'h52: g = {8'h7F, 8'h09, 8'h19, 8'h29, 8'h46};
            8'h53: g = {8'h46, 8'h49, 8'h49, 8'h49, 8'h31};
            8'h54: g = {8'h01, 8'h01, 8'h7F, 8'h01, 8'h01};
            8'h55: g = {8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F};
            8'h56: g = {8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F};
            8'h57: g = {8'h7F, 8'h20, 8'h18, 8'h20, 8'h7F};
            8'h58: g = {8'h63, 8'h14, 8'h08, 8'h14, 8'h63};
            8'h59: g = {8'h03, 8'h04, 8'h78, 8'h04, 8'h03};
            8'h5A: g = {8'h61, 8'h51, 8'h49, 8'h45, 8'h43};
            default: g = '0;
        endcase
        return g;
    endfunction

    // One pixel of the shadow; off-screen positions are ignored
    function automatic void shadow_plot(input int x, input int y, input logic lit);
        if (x < SCR_W && y < SCR_H)
        begin
            shadow_fb[x + (y / 8) * SCR_W][y % 8] = lit;
        end
    endfunction

    function automatic void owe_byte(input logic [7:0] b, input logic first,
                                     input logic last, input logic run_end);
        out_item_t o;
        o.out_byte     = b;
        o.packet_first = first;
        o.packet_last  = last;
        o.run_last     = run_end;
        bus_bytes_due.push_back(o);
    endfunction

    // Update the shadow framebuffer for one accepted item and queue the bus bytes it owes
    function automatic void shadow_apply(input in_item_t it);
        logic [7:0]      code;
        logic [0:4][7:0] cols;
        int              col;
        logic [7:0]      b;
        case (it.kind)
            KIND_CLEAR:
            begin
                clears_seen++;
                foreach (shadow_fb[i]) shadow_fb[i] = it.fill_byte;
            end
            KIND_PIXEL:
            begin
                pixels_seen++;
                shadow_plot(int'(it.x_pos), int'(it.y_pos), it.pixel_on);
            end
            KIND_CHAR:
            begin
                chars_seen++;
                // a cell that would run past the right edge is dropped whole
                if (it.x_pos <= SCR_W - GLYPH_MARGIN)
                begin
                    code = it.char_code;
                    if (code >= 8'h61 && code <= 8'h7A) code = code - 8'h20;
                    cols = font_columns(code);
                    for (int c = 0; c < 5; c++)
                    begin
                        for (int r = 0; r < 7; r++)
                        begin
                            shadow_plot((it.x_pos + c) & 8'hFF, (it.y_pos + r) & 8'hFF,
                                        cols[c][r]);
                        end
                    end
                end
            end
            default:
            begin
                flushes_seen++;
                // chunk 0 carries the page and column address commands first
                if (it.chunk_index == 3'd0)
                begin
                    owe_byte(CTRL_CMD, 1'b1, 1'b0, 1'b0);
                    owe_byte(CMD_PAGE_BASE + it.page_index, 1'b0, 1'b1, 1'b0);
                    owe_byte(CTRL_CMD, 1'b1, 1'b0, 1'b0);
                    owe_byte(CMD_COL_LOW, 1'b0, 1'b1, 1'b0);
                    owe_byte(CTRL_CMD, 1'b1, 1'b0, 1'b0);
                    owe_byte(CMD_COL_HIGH, 1'b0, 1'b1, 1'b0);
                end
                owe_byte(CTRL_DATA, 1'b1, 1'b0, 1'b0);
                for (int i = 0; i < CHUNK_LEN; i++)
                begin
                    col = it.chunk_index * CHUNK_LEN + i;
                    b   = 8'h00;
                    if (it.page_index < PAGES && col < SCR_W)
                        b = shadow_fb[it.page_index * SCR_W + col];
                    owe_byte(b, 1'b0, i == CHUNK_LEN - 1, i == CHUNK_LEN - 1);
                end
            end
        endcase
    endfunction

    // Send one item, with an optional random gap ahead of it; valid stays up afterwards
    task automatic send_item(input in_item_t it);
        int gap;
        if (idle_enabled && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 11);
            repeat (gap)
            begin
                @(negedge clk);
                item_ch.valid <= 1'b0;
            end
        end
        @(negedge clk);
        item_ch.valid   <= 1'b1;
        item_ch.payload <= it;
        @(posedge clk);
        while (!item_ch.ready) @(posedge clk);
        items_accepted++;
        shadow_apply(it);
    endtask

    function automatic in_item_t random_item();
        in_item_t it;
        it.kind        = kind_t'($urandom_range(0, 3));
        it.x_pos       = 8'($urandom_range(0, 255));
        it.y_pos       = 8'($urandom_range(0, 255));
        it.pixel_on    = 1'($urandom_range(0, 1));
        it.fill_byte   = 8'($urandom_range(0, 255));
        it.char_code   = 8'($urandom_range(0, 255));
        it.page_index  = 3'($urandom_range(0, 7));
        it.chunk_index = 3'($urandom_range(0, 7));
        return it;
    endfunction

    task automatic send_clear(input logic [7:0] fill);
        in_item_t it;
        it           = random_item();
        it.kind      = KIND_CLEAR;
        it.fill_byte = fill;
        send_item(it);
    endtask

    task automatic send_pixel(input logic [7:0] x, input logic [7:0] y, input logic lit);
        in_item_t it;
        it          = random_item();
        it.kind     = KIND_PIXEL;
        it.x_pos    = x;
        it.y_pos    = y;
        it.pixel_on = lit;
        send_item(it);
    endtask

    task automatic send_char(input logic [7:0] x, input logic [7:0] y, input logic [7:0] ch);
        in_item_t it;
        it           = random_item();
        it.kind      = KIND_CHAR;
        it.x_pos     = x;
        it.y_pos     = y;
        it.char_code = ch;
        send_item(it);
    endtask

    task automatic send_flush(input logic [2:0] page, input logic [2:0] chunk);
        in_item_t it;
        it             = random_item();
        it.kind        = KIND_FLUSH;
        it.page_index  = page;
        it.chunk_index = chunk;
        send_item(it);
    endtask

    // Store after the post-reset sweep reads back as zeros
    task automatic test_reset_contents();
        send_flush(3'd0, 3'd0);
    endtask

    // Fill byte lands in the store; one chunk is flushed to show it
    task automatic test_clear_fill();
        send_clear(8'hA5);
        send_flush(3'd3, 3'd2);
    endtask

    // Glyphs on a patterned background: fold, blank cell, right-edge drop, clip and wrap
    task automatic test_draw_char();
        send_char(8'd0, 8'd0, "A");
        send_char(8'd6, 8'd4, "z");           // lowercase, straddles pages 0 and 1
        send_char(8'd12, 8'd0, 8'h7E);        // no glyph: dark cell
        send_char(8'd122, 8'd56, "%");        // last column that still fits
        send_char(8'd123, 8'd8, "W");         // too far right, dropped
        send_char(8'd20, 8'd60, "Q");         // bottom rows clipped
        send_char(8'd30, 8'd254, "M");        // rows wrap past 255 to the top
        send_flush(3'd0, 3'd0);
        send_flush(3'd0, 3'd1);
        send_flush(3'd7, 3'd1);
        send_flush(3'd7, 3'd7);
        send_flush(3'd1, 3'd7);
    endtask

    // Corner pixels, set then cleared, and off-screen positions
    task automatic test_set_pixel();
        send_clear(8'h00);
        send_pixel(8'd0, 8'd0, 1'b1);
        send_pixel(8'd127, 8'd63, 1'b1);
        send_pixel(8'd126, 8'd63, 1'b1);
        send_pixel(8'd126, 8'd63, 1'b0);
        send_pixel(8'd128, 8'd0, 1'b1);
        send_pixel(8'd0, 8'd64, 1'b1);
        send_pixel(8'd255, 8'd255, 1'b1);
        send_flush(3'd0, 3'd0);
        send_flush(3'd7, 3'd7);
    endtask

    // Drawing aimed at one page, followed by flushes of the chunks it touched
    task automatic draw_and_flush_page();
        in_item_t it;
        int       page;
        int       col;
        int       n;
        page = $urandom_range(0, PAGES - 1);
        col  = $urandom_range(0, SCR_W - 1);
        n    = $urandom_range(1, 4);
        repeat (n)
        begin
            it      = random_item();
            it.kind = ($urandom_range(0, 1) == 0) ? KIND_PIXEL : KIND_CHAR;
            if ($urandom_range(0, 7) != 0)
            begin
                it.x_pos = 8'(col + $urandom_range(0, 10));
                it.y_pos = 8'(page * 8 + $urandom_range(0, 10) - 3);
            end
            if ($urandom_range(0, 3) != 0) it.char_code = 8'($urandom_range(8'h20, 8'h7A));
            send_item(it);
        end
        n = $urandom_range(1, 2);
        for (int k = 0; k < n; k++)
            send_flush(3'(page), 3'(((col / CHUNK_LEN) + k) & 7));
    endtask

    // Mostly draw-then-flush runs, with clears and fully random items mixed in
    task automatic test_random_traffic(input int count, input bit with_idle);
        int target;
        int pick;
        idle_enabled = with_idle;
        target       = items_accepted + count;
        while (items_accepted < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 5)
                send_clear(8'($urandom_range(0, 255)));
            else if (pick < 20)
                send_item(random_item());
            else
                draw_and_flush_page();
        end
    endtask

    // Output stalls in random bursts while idling is on
    initial
    begin
        int n;
        result_ch.ready = 1'b0;
        forever
        begin
            if (idle_enabled && $urandom_range(0, 2) == 0)
            begin
                n = $urandom_range(1, 11);
                repeat (n)
                begin
                    @(negedge clk);
                    result_ch.ready <= 1'b0;
                end
            end
            else
            begin
                n = $urandom_range(1, 16);
                repeat (n)
                begin
                    @(negedge clk);
                    result_ch.ready <= 1'b1;
                end
            end
        end
    end

    // Check each output beat against the oldest owed byte
    always @(posedge clk)
    begin
        out_item_t want;
        out_item_t got;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got = result_ch.payload;
            if (bus_bytes_due.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: unexpected beat byte=%h first=%b last=%b run_last=%b",
                             $realtime, got.out_byte, got.packet_first, got.packet_last,
                             got.run_last);
            end
            else
            begin
                want = bus_bytes_due.pop_front();
                beats_checked++;
                if (got.out_byte !== want.out_byte || got.packet_first !== want.packet_first
                    || got.packet_last !== want.packet_last || got.run_last !== want.run_last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: beat mismatch exp byte=%h first=%b last=%b run_last=%b",
                                 $realtime, want.out_byte, want.packet_first,
                                 want.packet_last, want.run_last,
                                 " got byte=%h first=%b last=%b run_last=%b",
                                 got.out_byte, got.packet_first, got.packet_last,
                                 got.run_last);
                end
            end
        end
    end

    // Main sequence
    initial
    begin
        rst_n           = 1'b0;
        item_ch.valid   = 1'b0;
        item_ch.payload = '0;
        idle_enabled    = 1'b1;
        items_accepted  = 0;
        clears_seen     = 0;
        pixels_seen     = 0;
        chars_seen      = 0;
        flushes_seen    = 0;
        beats_checked   = 0;
        mismatch_count  = 0;
        foreach (shadow_fb[i]) shadow_fb[i] = 8'h00;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_contents();
        test_clear_fill();
        test_draw_char();
        test_set_pixel();
        test_random_traffic(80, 1'b1);
        test_random_traffic(25, 1'b0);

        @(negedge clk);
        item_ch.valid <= 1'b0;

        // drain, then allow a trailing clear to finish
        while (bus_bytes_due.size() != 0) @(posedge clk);
        repeat (1100) @(posedge clk);

        if (mismatch_count > 10)
            $display("%0d further mismatches not shown", mismatch_count - 10);
        $display("Ran %0d items: %0d clears, %0d pixel writes, %0d glyphs, %0d flushes",
                 items_accepted, clears_seen, pixels_seen, chars_seen, flushes_seen);
        $display("Checked %0d bus bytes, %0d bad, %0d never seen",
                 beats_checked, mismatch_count, bus_bytes_due.size());
        if (mismatch_count == 0 && bus_bytes_due.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
